/* rtl/dq_pkg.sv */
// ----------------------------------------------------------------------------
// dq_pkg
// Shared constants, operation and status codes, and the controller/datapath
// command and status bundles of the bounded double-ended queue.
// ----------------------------------------------------------------------------
package dq_pkg;

    localparam int CAPACITY_DEF = 8;

    localparam int OP_W     = 2;
    localparam int WORD_W   = 32;
    localparam int STATUS_W = 2;
    localparam int FILL_W   = 4;

    localparam logic [OP_W-1:0] OP_PUSH_FRONT = 2'd0;
    localparam logic [OP_W-1:0] OP_PUSH_BACK  = 2'd1;
    localparam logic [OP_W-1:0] OP_POP_FRONT  = 2'd2;
    localparam logic [OP_W-1:0] OP_POP_BACK   = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd2;

    // controller -> datapath
    typedef struct packed {
        logic exec;      // carry out the accepted operation
        logic load_pop;  // capture the read word into the result register
    } t_dq_cmd;

    // datapath -> controller
    typedef struct packed {
        logic pop_hit;   // the offered operation is a pop on a non-empty queue
    } t_dq_stat;

endpackage

/* rtl/dq_ram.sv */
// ----------------------------------------------------------------------------
// dq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module dq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/dq_datapath.sv */
// ----------------------------------------------------------------------------
// dq_datapath
// Head index, word count, slot store and result registers of the deque.
// ----------------------------------------------------------------------------
module dq_datapath
    import dq_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_dq_cmd                    i_cmd,
    output t_dq_stat                   o_stat,
    input  logic [OP_W-1:0]            i_op,
    input  logic signed [WORD_W-1:0]   i_push_value,
    output logic signed [WORD_W-1:0]   o_popped_value,
    output logic [STATUS_W-1:0]        o_status,
    output logic [FILL_W-1:0]          o_fill_count
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int SUM_W = $clog2(2 * CAPACITY);

    logic [IDX_W-1:0]    r_head, n_head;
    logic [CNT_W-1:0]    r_count, n_count;
    logic [WORD_W-1:0]   r_popped;
    logic [STATUS_W-1:0] r_status, n_status;
    logic [FILL_W-1:0]   r_fill;

    logic              is_push, is_front, full, empty;
    logic [IDX_W-1:0]  head_dec, head_inc, tail_idx, back_idx;
    logic [SUM_W-1:0]  tail_sum, back_sum;
    logic              ram_we, ram_re;
    logic [IDX_W-1:0]  ram_waddr, ram_raddr;
    logic [WORD_W-1:0] ram_rdata;
    logic [CNT_W+FILL_W-1:0] fill_ext;

    assign is_push  = (i_op == OP_PUSH_FRONT) || (i_op == OP_PUSH_BACK);
    assign is_front = (i_op == OP_PUSH_FRONT) || (i_op == OP_POP_FRONT);
    assign full     = (r_count == CNT_W'(CAPACITY));
    assign empty    = (r_count == '0);

    // circular index arithmetic, wrap by one compare and subtract
    always_comb begin
        head_dec = (r_head == '0) ? IDX_W'(CAPACITY - 1) : r_head - 1'b1;
        head_inc = (r_head == IDX_W'(CAPACITY - 1)) ? '0 : r_head + 1'b1;
        tail_sum = SUM_W'(r_head) + SUM_W'(r_count);
        back_sum = tail_sum - 1'b1;
        tail_idx = (tail_sum >= SUM_W'(CAPACITY)) ? IDX_W'(tail_sum - SUM_W'(CAPACITY))
                                                  : IDX_W'(tail_sum);
        back_idx = (back_sum >= SUM_W'(CAPACITY)) ? IDX_W'(back_sum - SUM_W'(CAPACITY))
                                                  : IDX_W'(back_sum);
    end

    always_comb begin
        n_head   = r_head;
        n_count  = r_count;
        n_status = ST_OK;
        ram_we   = 1'b0;
        ram_re   = 1'b0;
        ram_waddr = is_front ? head_dec : tail_idx;
        ram_raddr = is_front ? r_head : back_idx;
        if (is_push) begin
            if (full) begin
                n_status = ST_OVERFLOW;
            end else begin
                ram_we  = i_cmd.exec;
                n_count = r_count + 1'b1;
                if (is_front) begin
                    n_head = head_dec;
                end
            end
        end else begin
            if (empty) begin
                n_status = ST_EMPTY;
            end else begin
                ram_re  = i_cmd.exec;
                n_count = r_count - 1'b1;
                if (is_front) begin
                    n_head = head_inc;
                end
            end
        end
    end

    assign o_stat.pop_hit = !is_push && !empty;
    assign fill_ext       = {{FILL_W{1'b0}}, n_count};

    dq_ram #(
        .WIDTH (WORD_W),
        .DEPTH (CAPACITY)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (i_push_value),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
        end else if (i_cmd.exec) begin
            r_head  <= n_head;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_status <= n_status;
            r_fill   <= fill_ext[FILL_W-1:0];
            r_popped <= '0;
        end else if (i_cmd.load_pop) begin
            r_popped <= ram_rdata;
        end
    end

    assign o_popped_value = r_popped;
    assign o_status       = r_status;
    assign o_fill_count   = r_fill;

endmodule

/* rtl/dq_ctrl.sv */
// ----------------------------------------------------------------------------
// dq_ctrl
// Handshake controller: accepts operations, waits out slot reads, and owns
// the result valid flag.
// ----------------------------------------------------------------------------
module dq_ctrl
    import dq_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    input  t_dq_stat i_stat,
    output t_dq_cmd  o_cmd
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_READ = 1'b1;

    logic r_state, n_state;
    logic r_out_valid, n_out_valid;
    logic can_take;

    // take a word when idle and the result register is free or being emptied
    assign can_take = (r_state == S_IDLE) && (!r_out_valid || i_out_ready);

    always_comb begin
        n_state        = r_state;
        n_out_valid    = r_out_valid;
        o_cmd.exec     = 1'b0;
        o_cmd.load_pop = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (r_out_valid && i_out_ready) begin
                    n_out_valid = 1'b0;
                end
                if (can_take && i_in_valid) begin
                    o_cmd.exec = 1'b1;
                    if (i_stat.pop_hit) begin
                        n_state = S_READ;
                    end else begin
                        n_out_valid = 1'b1;
                    end
                end
            end
            S_READ: begin
                o_cmd.load_pop = 1'b1;
                n_out_valid    = 1'b1;
                n_state        = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = can_take;
    assign o_out_valid = r_out_valid;

endmodule

/* rtl/bounded_double_ended_queue.sv */
// ----------------------------------------------------------------------------
// bounded_double_ended_queue
// Fixed-capacity double-ended queue of signed 32-bit words.
//   A push or refused pop has its result in the cycle after acceptance; a
//   pop that returns a word goes through the slot RAM read register, then
//   the result register. One push per cycle while results are taken; a
//   returning pop holds off the next word until its slot read lands.
//   Reset (synchronous, active low) empties the queue: head and count clear,
//   slot contents stay undefined until written; no clearing pass.
// ----------------------------------------------------------------------------
module bounded_double_ended_queue
    import dq_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // operation channel
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic [OP_W-1:0]           i_op,
    input  logic signed [WORD_W-1:0]  i_push_value,
    // result channel
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic signed [WORD_W-1:0]  o_popped_value,
    output logic [STATUS_W-1:0]       o_status,
    output logic [FILL_W-1:0]         o_fill_count
);

    t_dq_cmd  cmd;
    t_dq_stat stat;

    // Controller: decide when a word is taken and when the slot read lands.
    dq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    // Datapath: circular buffer addressed by head index and count; results
    // hold in their registers until the downstream side takes them.
    dq_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_op           (i_op),
        .i_push_value   (i_push_value),
        .o_popped_value (o_popped_value),
        .o_status       (o_status),
        .o_fill_count   (o_fill_count)
    );

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench for bounded_double_ended_queue. Words go in on the
// operation channel. A local copy of the deque state predicts the result of
// every accepted word, and each returned result is checked field by field
// against the oldest prediction. The run has directed corner cases, a
// long receiver hold-off, and random phases biased toward fill, drain or
// balanced traffic, with random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb_top;
    import dq_pkg::*;

    localparam int DEPTH       = CAPACITY_DEF;
    localparam int SLOT_W      = $clog2(DEPTH);
    localparam int CYCLE_LIMIT = 300000;
    localparam int MAX_SHOWN   = 10;
    localparam int RANDOM_WORDS = 880;

    typedef struct packed {
        logic [WORD_W-1:0]   popped;
        logic [STATUS_W-1:0] status;
        logic [FILL_W-1:0]   fill;
    } t_deque_result;

    // receiver behavior
    typedef enum int {RX_ALWAYS, RX_PATTERN, RX_RANDOM} t_rx_mode;

    logic                     i_clk        = 1'b0;
    logic                     i_rst_n      = 1'b0;
    logic                     i_in_valid   = 1'b0;
    logic                     o_in_ready;
    logic [OP_W-1:0]          i_op         = OP_PUSH_BACK;
    logic signed [WORD_W-1:0] i_push_value = '0;
    logic                     o_out_valid;
    logic                     i_out_ready  = 1'b0;
    logic signed [WORD_W-1:0] o_popped_value;
    logic [STATUS_W-1:0]      o_status;
    logic [FILL_W-1:0]        o_fill_count;

    bounded_double_ended_queue #(
        .CAPACITY(DEPTH)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_op          (i_op),
        .i_push_value  (i_push_value),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_popped_value(o_popped_value),
        .o_status      (o_status),
        .o_fill_count  (o_fill_count)
    );

    // 8 ns clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Predicted deque state: circular buffer addressed by head and count.
    // ------------------------------------------------------------------------
    logic [WORD_W-1:0] deque_slots [DEPTH];
    int                deque_head  = 0;
    int                deque_count = 0;

    t_deque_result pending_results[$];

    // run statistics
    int cycle_count   = 0;
    int words_sent    = 0;
    int results_seen  = 0;
    int push_ok_cnt   = 0;
    int pop_ok_cnt    = 0;
    int overflow_cnt  = 0;
    int empty_cnt     = 0;
    int wrap_fronts   = 0;
    int mismatch_cnt  = 0;

    // sender idling: bursts of random length separated by random gaps
    bit gap_enable = 1'b0;
    int burst_left = 0;

    // receiver control; hold-off requests are handed over by toggling hold_go
    t_rx_mode  rx_mode   = RX_ALWAYS;
    bit        hold_go   = 1'b0;
    bit        hold_seen = 1'b0;
    int        hold_len  = 0;
    int        hold_left = 0;
    logic [7:0] rx_pattern = 8'b1011_0111;
    int        pattern_age = 0;

    // Apply one operation to the predicted state and return the expected result.
    function automatic t_deque_result predict_deque_op(input logic [OP_W-1:0] op,
                                                       input logic [WORD_W-1:0] word);
        t_deque_result res;
        int            pos;
        res.popped = '0;
        res.status = ST_OK;
        if (op == OP_PUSH_FRONT || op == OP_PUSH_BACK) begin
            if (deque_count >= DEPTH) begin
                res.status = ST_OVERFLOW;
            end else if (op == OP_PUSH_FRONT) begin
                // step head back one slot, wrapping, and write there
                deque_head = (deque_head + DEPTH - 1) % DEPTH;
                deque_slots[SLOT_W'(deque_head)] = word;
                deque_count++;
            end else begin
                pos = (deque_head + deque_count) % DEPTH;
                deque_slots[SLOT_W'(pos)] = word;
                deque_count++;
            end
        end else begin
            if (deque_count == 0) begin
                res.status = ST_EMPTY;
            end else if (op == OP_POP_FRONT) begin
                res.popped = deque_slots[SLOT_W'(deque_head)];
                deque_head = (deque_head + 1) % DEPTH;
                deque_count--;
            end else begin
                pos = (deque_head + deque_count - 1) % DEPTH;
                res.popped = deque_slots[SLOT_W'(pos)];
                deque_count--;
            end
        end
        res.fill = deque_count[FILL_W-1:0];
        return res;
    endfunction

    // Offer one word, hold it until accepted, then record its prediction.
    // Called at a falling edge; returns at a falling edge.
    task automatic send_word(input logic [OP_W-1:0] op, input logic [WORD_W-1:0] word);
        t_deque_result res;
        i_op         = op;
        i_push_value = word;
        i_in_valid   = 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        if (op == OP_PUSH_FRONT && deque_count > 0 && deque_count < DEPTH
            && deque_head == 0)
            wrap_fronts++;
        res = predict_deque_op(op, word);
        pending_results.push_back(res);
        words_sent++;
        case (res.status)
            ST_OVERFLOW: overflow_cnt++;
            ST_EMPTY:    empty_cnt++;
            default: begin
                if (op == OP_PUSH_FRONT || op == OP_PUSH_BACK) push_ok_cnt++;
                else pop_ok_cnt++;
            end
        endcase
        @(negedge i_clk);
        // end of a burst: drop valid for a random gap
        if (gap_enable) begin
            if (burst_left == 0) begin
                i_in_valid = 1'b0;
                repeat ($urandom_range(1, 6)) @(negedge i_clk);
                burst_left = $urandom_range(1, 12);
            end else begin
                burst_left--;
            end
        end
    endtask

    // Stop offering and wait until every predicted result has come back.
    task automatic drain_results();
        i_in_valid = 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Words weighted toward the extremes and small values, the rest random.
    function automatic logic [WORD_W-1:0] pick_word();
        case ($urandom_range(0, 7))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return '0;
            3:       return '1;
            4:       return $urandom_range(0, 15);
            default: return $urandom();
        endcase
    endfunction

    // Random operation; push_pct sets the share of pushes.
    function automatic logic [OP_W-1:0] pick_op(input int push_pct);
        bit push_side;
        bit front_side;
        push_side  = ($urandom_range(0, 99) < push_pct);
        front_side = 1'($urandom_range(0, 1));
        if (push_side) return front_side ? OP_PUSH_FRONT : OP_PUSH_BACK;
        return front_side ? OP_POP_FRONT : OP_POP_BACK;
    endfunction

    // ------------------------------------------------------------------------
    // Receiver: ready changes at the falling edge. A pending hold-off wins,
    // then the current stall mode decides.
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (hold_go != hold_seen) begin
            hold_seen = hold_go;
            hold_left = hold_len;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready = 1'b0;
        end else begin
            case (rx_mode)
                RX_ALWAYS: i_out_ready = 1'b1;
                RX_PATTERN: begin
                    // rotate a stall pattern, reload it now and then
                    i_out_ready = rx_pattern[0];
                    rx_pattern  = {rx_pattern[0], rx_pattern[7:1]};
                    pattern_age++;
                    if (pattern_age == 32) begin
                        pattern_age = 0;
                        rx_pattern  = 8'($urandom()) | 8'h01;
                    end
                end
                default: i_out_ready = ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    // Report a mismatch; only the first few are printed.
    task automatic note_mismatch(input string what, input logic [WORD_W-1:0] want,
                                 input logic [WORD_W-1:0] got);
        mismatch_cnt++;
        if (mismatch_cnt <= MAX_SHOWN)
            $display("[%0t] mismatch on %s: expected 0x%08h, got 0x%08h",
                     $time, what, want, got);
    endtask

    // ------------------------------------------------------------------------
    // Result check: every accepted result against the oldest prediction.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : result_check
        t_deque_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                note_mismatch("unexpected result word", '0, o_popped_value);
            end else begin
                want = pending_results.pop_front();
                if (o_popped_value !== want.popped)
                    note_mismatch("popped_value", want.popped, o_popped_value);
                if (o_status !== want.status)
                    note_mismatch("status", WORD_W'(want.status), WORD_W'(o_status));
                if (o_fill_count !== want.fill)
                    note_mismatch("fill_count", WORD_W'(want.fill),
                                  WORD_W'(o_fill_count));
            end
        end
    end

    // Watchdog: end a hung run.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_results.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Pops on an empty deque are refused with the empty status.
    task automatic test_empty_pops();
        send_word(OP_POP_FRONT, 32'h1234_5678);
        send_word(OP_POP_BACK, '1);
        drain_results();
    endtask

    // Fill from both ends with extreme words, then push into a full deque.
    task automatic test_fill_and_overflow();
        send_word(OP_PUSH_FRONT, 32'h7FFF_FFFF);
        send_word(OP_PUSH_BACK,  32'h8000_0000);
        send_word(OP_PUSH_FRONT, '1);
        send_word(OP_PUSH_BACK,  '0);
        send_word(OP_PUSH_FRONT, 32'h0000_0001);
        send_word(OP_PUSH_BACK,  32'hAAAA_AAAA);
        send_word(OP_PUSH_FRONT, 32'h5555_5555);
        send_word(OP_PUSH_BACK,  32'hFFFF_FFFE);
        send_word(OP_PUSH_FRONT, 32'hDEAD_0001);
        send_word(OP_PUSH_BACK,  32'hDEAD_0002);
        drain_results();
    endtask

    // Pop from both ends, push twice at the front, drain from the back across
    // the wrap point, and pop a single stored word.
    task automatic test_wrap_and_last_word();
        send_word(OP_POP_FRONT, '0);
        send_word(OP_POP_BACK,  '0);
        send_word(OP_POP_FRONT, '0);
        send_word(OP_PUSH_FRONT, 32'hC0DE_0001);
        send_word(OP_PUSH_FRONT, 32'hC0DE_0002);
        repeat (7) send_word(OP_POP_BACK, '0);
        send_word(OP_PUSH_BACK, 32'h8000_0001);
        send_word(OP_POP_FRONT, '0);
        drain_results();
    endtask

    // Hold the receiver off for a long stretch while words keep coming, so the
    // result register stays full and the block stalls its input.
    task automatic test_output_backpressure();
        gap_enable = 1'b0;
        rx_mode    = RX_ALWAYS;
        hold_len   = 80;
        hold_go    = ~hold_go;
        repeat (40) send_word(pick_op(60), pick_word());
        drain_results();
    endtask

    // Random phases: fill-heavy, drain-heavy or balanced traffic, each with
    // its own sender gaps and receiver stalls, some with no idling at all.
    task automatic test_random_phases(input int total);
        int left;
        int seg;
        int push_pct;
        left = total;
        while (left > 0) begin
            seg = $urandom_range(10, 40);
            if (seg > left) seg = left;
            case ($urandom_range(0, 2))
                0:       push_pct = 80;
                1:       push_pct = 20;
                default: push_pct = 50;
            endcase
            gap_enable = $urandom_range(0, 2) != 0;
            burst_left = $urandom_range(0, 12);
            case ($urandom_range(0, 2))
                0:       rx_mode = RX_ALWAYS;
                1:       rx_mode = RX_PATTERN;
                default: rx_mode = RX_RANDOM;
            endcase
            repeat (seg) send_word(pick_op(push_pct), pick_word());
            left -= seg;
        end
        drain_results();
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        gap_enable = 1'b1;
        rx_mode    = RX_PATTERN;
        test_empty_pops();
        test_fill_and_overflow();
        rx_mode = RX_RANDOM;
        test_wrap_and_last_word();
        test_output_backpressure();
        test_random_phases(RANDOM_WORDS);

        // let any stray result show up before the verdict
        rx_mode = RX_ALWAYS;
        repeat (8) @(posedge i_clk);

        $display("covered %0d words: %0d pushes, %0d pops, %0d overflows, %0d empty pops",
                 words_sent, push_ok_cnt, pop_ok_cnt, overflow_cnt, empty_cnt);
        $display("%0d front pushes across the wrap, %0d results checked, %0d mismatches",
                 wrap_fronts, results_seen, mismatch_cnt);
        if (mismatch_cnt == 0 && pending_results.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
